/* rtl/core/pli_pkg.sv */
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types and constants for the piecewise linear interpolator: table
// geometry, divider widths, command and result transaction layouts.
// ----------------------------------------------------------------------------
package pli_pkg;

  // Table geometry
  localparam int unsigned MAX_POINTS = 64;
  localparam int unsigned X_BITS     = 16;
  localparam int unsigned ADDR_W     = $clog2(MAX_POINTS);
  localparam int unsigned N_W        = $clog2(MAX_POINTS + 1);

  // Fixed field widths of the transactions
  localparam int unsigned OPX_W = 16;
  localparam int unsigned IDX_W = 6;
  localparam int unsigned Y_W   = 32;
  localparam int unsigned CNT_W = 7;

  // Divider widths: |dy| magnitude, product, iteration counter
  localparam int unsigned MAG_W  = Y_W + 1;
  localparam int unsigned PROD_W = MAG_W + X_BITS;
  localparam int unsigned DCNT_W = $clog2(MAG_W + 1);

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef struct packed {
    op_e                     operation;
    logic [IDX_W-1:0]        point_index;
    logic [OPX_W-1:0]        point_x;
    logic signed [Y_W-1:0]   point_y;
    logic [OPX_W-1:0]        query_x;
  } cmd_t;

  typedef struct packed {
    logic signed [Y_W-1:0]   value;
    logic [CNT_W-1:0]        segment;
  } res_t;

  // One stored breakpoint
  typedef struct packed {
    logic [X_BITS-1:0]       x;
    logic [Y_W-1:0]          y;
  } entry_t;

  localparam int unsigned ENTRY_W = X_BITS + Y_W;

endpackage

/* rtl/core/piecewise_linear_interpolator.sv */
// A load gives no result. A clamped query strobes its result after the first
// and last breakpoints are read and checked, an interpolated one after the
// table walk, the multiply and the 33 divide steps.
// Throughput: one transaction at a time; busy is high until the result cycle,
// in which the next one can be accepted. The result strobe cannot be stalled.
// Reset: point_count returns to 1; table contents are kept and undefined.
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// Breakpoint table with linear interpolation between neighboring points,
// clamping at both ends and 32-bit saturation of the result.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  pli_pkg::cmd_t                cmd_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [pli_pkg::CNT_W-1:0]    cfg_data_i,
  output logic                         result_valid_o,
  output pli_pkg::res_t                result_o
);
  import pli_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD0  = 3'd1;
  localparam logic [2:0] S_RDL  = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_WALK = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;

  localparam int signed SUM_W = Y_W + 3;

  logic [2:0]            state_q, state_d;
  logic [CNT_W-1:0]      point_count_q;
  logic [N_W-1:0]        n_q, n_eff;
  logic [X_BITS-1:0]     qx_q;
  logic [ADDR_W-1:0]     j_q, j_d;
  logic [X_BITS-1:0]     xlo_q;
  logic [Y_W-1:0]        ylo_q;
  logic                  neg_q;
  logic                  res_valid_q, res_valid_d;
  res_t                  res_q, res_d;

  logic                  accept, wr_en, rd_en;
  logic [ADDR_W-1:0]     rd_addr;
  logic [ENTRY_W-1:0]    rd_raw;
  entry_t                rd_ent, wr_ent;
  logic                  lo_load;

  logic signed [MAG_W-1:0]  dy;
  logic [MAG_W-1:0]         mag;
  logic                     div_start, div_done;
  logic [MAG_W-1:0]         quo;
  logic signed [SUM_W-1:0]  sum;
  logic signed [Y_W-1:0]    sat;

  assign accept      = start && !busy;
  assign busy        = state_q != S_IDLE;
  assign cfg_ready_o = !busy;

  // Effective point count: 0 acts as 1, large values clamp to the table size
  always_comb begin
    if (point_count_q == '0) begin
      n_eff = N_W'(1);
    end else if (32'(point_count_q) > MAX_POINTS) begin
      n_eff = N_W'(MAX_POINTS);
    end else begin
      n_eff = N_W'(point_count_q);
    end
  end

  // Breakpoint table
  assign wr_en    = accept && cmd_i.operation == OP_LOAD &&
                    32'(cmd_i.point_index) < MAX_POINTS;
  assign wr_ent.x = X_BITS'(cmd_i.point_x);
  assign wr_ent.y = cmd_i.point_y;
  assign rd_ent   = entry_t'(rd_raw);

  pli_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (ADDR_W'(cmd_i.point_index)),
    .wdata_i (ENTRY_W'(wr_ent)),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_raw)
  );

  // Segment slope terms from the lower point and the entry just read
  assign dy  = $signed({rd_ent.y[Y_W-1], rd_ent.y}) - $signed({ylo_q[Y_W-1], ylo_q});
  assign mag = dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);

  pli_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .mag_i   (mag),
    .dq_i    (qx_q - xlo_q),
    .dx_i    (rd_ent.x - xlo_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // Final add or subtract and 32-bit saturation
  assign sum = neg_q ? SUM_W'($signed(ylo_q)) - $signed(SUM_W'(quo))
                     : SUM_W'($signed(ylo_q)) + $signed(SUM_W'(quo));
  always_comb begin
    if (sum > SUM_W'(32'sh7FFF_FFFF)) begin
      sat = 32'sh7FFF_FFFF;
    end else if (sum < -SUM_W'(33'sh0_8000_0000)) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = Y_W'(sum);
    end
  end

  // Query sequencer
  always_comb begin
    state_d     = state_q;
    j_d         = j_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    lo_load     = 1'b0;
    div_start   = 1'b0;
    res_valid_d = 1'b0;
    res_d       = res_q;
    case (state_q)
      S_IDLE: begin
        if (accept && cmd_i.operation == OP_QUERY) begin
          state_d = S_RD0;
        end
      end
      S_RD0: begin
        rd_en   = 1'b1;
        state_d = S_RDL;
      end
      S_RDL: begin
        lo_load = 1'b1;
        rd_en   = 1'b1;
        rd_addr = ADDR_W'(n_q - N_W'(1));
        state_d = S_CHK;
      end
      S_CHK: begin
        if (qx_q <= xlo_q) begin
          res_d.value   = ylo_q;
          res_d.segment = '0;
          res_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end else if (qx_q >= rd_ent.x) begin
          res_d.value   = rd_ent.y;
          res_d.segment = CNT_W'(n_q);
          res_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ADDR_W'(1);
          j_d     = ADDR_W'(1);
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if ((N_W'(j_q) + N_W'(1)) < n_q && !(qx_q < rd_ent.x)) begin
          lo_load = 1'b1;
          rd_en   = 1'b1;
          rd_addr = j_q + ADDR_W'(1);
          j_d     = j_q + ADDR_W'(1);
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_d.value   = sat;
          res_d.segment = CNT_W'(j_q);
          res_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      point_count_q <= CNT_W'(1);
      res_valid_q   <= 1'b0;
      j_q           <= '0;
      n_q           <= N_W'(1);
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      j_q         <= j_d;
      if (cfg_valid_i && cfg_ready_o) begin
        point_count_q <= cfg_data_i;
      end
      if (accept) begin
        n_q <= n_eff;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      qx_q <= X_BITS'(cmd_i.query_x);
    end
    if (lo_load) begin
      xlo_q <= rd_ent.x;
      ylo_q <= rd_ent.y;
    end
    if (div_start) begin
      neg_q <= dy[MAG_W-1];
    end
    res_q <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

`ifndef SYNTHESIS
  // A result marks the return to idle
  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while busy");

  // A load transaction never produces a result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i.operation == OP_LOAD) |=> !result_valid_o)
    else $error("result after load");

  // The walk stays inside the active table
  a_walk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (N_W'(j_q) < n_q && j_q != '0))
    else $error("walk index out of range");

  // The divider only finishes while the sequencer waits for it
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider done outside division phase");

  // Segment never exceeds the effective point count
  a_seg_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> 32'(result_o.segment) <= 32'(n_q))
    else $error("segment above point count");
`endif

endmodule

/* rtl/core/pli_ram.sv */
// ----------------------------------------------------------------------------
// pli_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pli_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/pli_div.sv */
// ----------------------------------------------------------------------------
// pli_div
// Scaled quotient unit: floor(mag * dq / dx) with dq < dx. A multiply
// step, then a restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pli_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [pli_pkg::MAG_W-1:0]         mag_i,
  input  logic [pli_pkg::X_BITS-1:0]        dq_i,
  input  logic [pli_pkg::X_BITS-1:0]        dx_i,
  output logic                              done_o,
  output logic [pli_pkg::MAG_W-1:0]         quo_o
);
  import pli_pkg::*;

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_MUL  = 2'd1;
  localparam logic [1:0] D_RUN  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [MAG_W-1:0]  a_q;
  logic [X_BITS-1:0] b_q, dx_q;
  logic [MAG_W-1:0]  pq_q, pq_d;
  logic [X_BITS-1:0] rem_q, rem_d;
  logic [PROD_W-1:0] prod;
  logic [X_BITS:0]   rem2, rem_sub;
  logic              ge;

  // Product of magnitude and offset; upper part is below dx since dq < dx
  assign prod = PROD_W'(a_q) * PROD_W'(b_q);

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign rem2    = {rem_q, pq_q[MAG_W-1]};
  assign ge      = rem2 >= {1'b0, dx_q};
  assign rem_sub = rem2 - {1'b0, dx_q};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    pq_d    = pq_q;
    rem_d   = rem_q;
    case (state_q)
      D_IDLE: begin
        if (start_i) begin
          state_d = D_MUL;
        end
      end
      D_MUL: begin
        pq_d    = prod[MAG_W-1:0];
        rem_d   = prod[PROD_W-1:MAG_W];
        cnt_d   = DCNT_W'(MAG_W);
        state_d = D_RUN;
      end
      D_RUN: begin
        pq_d  = {pq_q[MAG_W-2:0], ge};
        rem_d = ge ? rem_sub[X_BITS-1:0] : rem2[X_BITS-1:0];
        cnt_d = cnt_q - DCNT_W'(1);
        if (cnt_q == DCNT_W'(1)) begin
          done_d  = 1'b1;
          state_d = D_IDLE;
        end
      end
      default: begin
        state_d = D_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == D_IDLE && start_i) begin
      a_q  <= mag_i;
      b_q  <= dq_i;
      dx_q <= dx_i;
    end
    pq_q  <= pq_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o  = pq_q;

endmodule
